### hw/rtl/mdlex_pkg.sv
// Package: constants and types for the multi-DFA longest-match lexer.
`default_nettype none
package mdlex_pkg;

  localparam int NumPatterns = 4;
  localparam int NumStates   = 16;
  localparam int Lookahead   = 64;

  localparam int PatW   = $clog2(NumPatterns);
  localparam int StW    = $clog2(NumStates);
  localparam int BufAw  = $clog2(Lookahead);
  localparam int CntW   = BufAw + 1;
  localparam int PcntW  = $clog2(NumPatterns + 1);

  localparam int LenW   = 7;
  localparam int IdW    = 3;
  localparam int ModeW  = 2;
  localparam int CfgAw  = 3;
  localparam int CfgDw  = 32;
  localparam int ActW   = 3;

  typedef logic signed [7:0] pos_t;
  localparam pos_t PosNoMatch    = -8'sd2;
  localparam pos_t PosEmptyMatch = -8'sd1;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD_TRANS  = 2'd0,
    MODE_LOAD_ACCEPT = 2'd1,
    MODE_SYMBOL      = 2'd2,
    MODE_NONE        = 2'd3
  } mode_t;

  localparam logic [CfgAw-1:0] RegActivePatterns = 3'd0;
  localparam logic [ActW-1:0]  ActiveReset       = 3'd4;

  typedef struct packed {
    logic [LenW-1:0] token_length;
    logic [LenW-1:0] consumed_length;
    logic [IdW-1:0]  token_id;
    logic            overflow;
  } result_t;

endpackage : mdlex_pkg
`default_nettype wire

### hw/rtl/multi_dfa_longest_match_lexer_unit.sv
// Top level: multi-DFA longest-match lexer with sequential per-DFA table unit.
//
// Channel | Dir | Handshake              | Content
// in_     | in  | in_tvalid/in_tready    | table loads and text symbols
// out_   | out | out_tvalid/out_tready  | one token decision per transfer
// cfg_    | in  | APB psel/penable       | active_patterns register
//
// A symbol is scanned position by position: at a token start each active DFA
// is reset and its start acceptance read, then at each position every live
// active DFA is stepped and its acceptance recorded; a decision compares the
// active DFAs in turn; rescans after a backtrack repeat the per-position work.
// The table-read unit is shared, so the DFAs are handled one at a time.
// in_tready is low while a symbol is being processed; results wait in a
// pending register and an output register while out_tready is low.
// Reset is synchronous; tables and buffer contents are undefined until written.
`default_nettype none
module multi_dfa_longest_match_lexer_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [1:0] pattern_sel, [5:2] state_sel, [6] symbol, [10:7] next_state,
  // [11] next_dead, [12] accepting, [15:13] zero
  input  wire logic [15:0]               in_tdata,
  // [1:0] mode
  input  wire logic [1:0]                in_tuser,
  input  wire logic                      in_tlast,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [6:0] token_length, [13:7] consumed_length, [16:14] token_id, [23:17] zero
  output logic [23:0]                    out_tdata,
  // [0] overflow
  output logic                           out_tuser,
  output logic                           out_tlast,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [2:0]                cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import mdlex_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SYM, ST_START_RD, ST_START_WR, ST_FEED_RD, ST_FEED_WR,
    ST_REC_RD, ST_REC_WR, ST_DEC_CMP, ST_DEC_EMIT, ST_FINISH
  } state_t;

  state_t                  state_r;
  logic [ActW-1:0]         active_r;
  logic [BufAw-1:0]        head_r;
  logic [CntW-1:0]         count_r;
  logic [CntW-1:0]         scan_r;
  logic [PcntW-1:0]        p_r;
  logic                    eot_r;
  logic                    forced_r;
  logic [NumPatterns-1:0]  dead_r;
  logic [StW-1:0]          pst_r [NumPatterns];
  pos_t                    best_r [NumPatterns];
  logic [PatW-1:0]         win_r;
  pos_t                    winval_r;
  logic                    pend_v_r;
  result_t                 pend_r;
  logic                    out_v_r;
  result_t                 out_r;
  logic                    out_last_r;

  logic [4:0]              trans_mem [2*NumPatterns*NumStates];
  logic                    acc_mem   [NumPatterns*NumStates];
  logic                    buf_mem   [Lookahead];
  logic [4:0]              trans_q;
  logic                    acc_q;
  logic                    buf_q;

  logic [PatW-1:0]         pi;
  logic [PcntW-1:0]        n_act;
  logic [NumPatterns-1:0]  act_mask;
  logic                    all_dead;
  logic                    out_free;
  logic                    out_load;
  logic                    in_fire;
  mode_t                   in_mode;
  logic [PatW-1:0]         in_pat;
  logic [StW-1:0]          in_st;
  logic                    in_sym;
  logic [StW-1:0]          in_next;
  logic                    in_ndead;
  logic                    in_acc;
  logic [StW+PatW:0]       trans_ra;
  logic [StW+PatW-1:0]     acc_ra;
  logic [BufAw-1:0]        buf_ra;
  logic                    cfg_wr;
  result_t                 dec_res;
  logic [LenW-1:0]         dec_cons;
  logic [LenW-1:0]         dec_tlen;
  logic [IdW-1:0]          dec_id;

  assign in_mode  = mode_t'(in_tuser);
  assign in_pat   = in_tdata[1:0];
  assign in_st    = in_tdata[5:2];
  assign in_sym   = in_tdata[6];
  assign in_next  = in_tdata[10:7];
  assign in_ndead = in_tdata[11];
  assign in_acc   = in_tdata[12];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign out_load  = pend_v_r && out_free &&
                     (state_r == ST_DEC_EMIT || state_r == ST_FINISH);
  assign pi        = p_r[PatW-1:0];

  always_comb begin
    if (active_r == '0) begin
      n_act = PcntW'(1);
    end else if (active_r > ActW'(NumPatterns)) begin
      n_act = PcntW'(NumPatterns);
    end else begin
      n_act = PcntW'(active_r);
    end
  end

  always_comb begin
    for (int i = 0; i < NumPatterns; i++) begin
      act_mask[i] = (PcntW'(i) < n_act);
    end
  end
  assign all_dead = ((dead_r & act_mask) == act_mask);

  assign trans_ra = {pi, pst_r[pi], buf_q};
  assign acc_ra   = (state_r == ST_START_RD) ? {pi, StW'(0)} : {pi, pst_r[pi]};
  assign buf_ra   = head_r + scan_r[BufAw-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_LOAD_TRANS) begin
      trans_mem[{in_pat, in_st, in_sym}] <= {in_ndead, in_next};
    end
    if (in_fire && in_mode == MODE_LOAD_ACCEPT) begin
      acc_mem[{in_pat, in_st}] <= in_acc;
    end
    if (in_fire && in_mode == MODE_SYMBOL && count_r < CntW'(Lookahead)) begin
      buf_mem[head_r + count_r[BufAw-1:0]] <= in_sym;
    end
    trans_q <= trans_mem[trans_ra];
    acc_q   <= acc_mem[acc_ra];
    buf_q   <= buf_mem[buf_ra];
  end

  always_comb begin
    if (winval_r < 0) begin
      dec_cons = (scan_r == '0) ? LenW'(1) : LenW'(scan_r);
      dec_tlen = (winval_r == PosNoMatch) ? dec_cons : '0;
      dec_id   = '0;
    end else begin
      dec_cons = LenW'(winval_r[6:0]) + LenW'(1);
      dec_tlen = dec_cons;
      dec_id   = IdW'(win_r) + IdW'(1);
    end
    if (dec_cons > LenW'(count_r)) dec_cons = LenW'(count_r);
    dec_res.token_length    = dec_tlen;
    dec_res.consumed_length = dec_cons;
    dec_res.token_id        = dec_id;
    dec_res.overflow        = forced_r;
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= ActiveReset;
      head_r   <= '0;
      count_r  <= '0;
      scan_r   <= '0;
      p_r      <= '0;
      eot_r    <= 1'b0;
      forced_r <= 1'b0;
      dead_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      win_r    <= '0;
      for (int i = 0; i < NumPatterns; i++) begin
        pst_r[i]  <= '0;
        best_r[i] <= PosNoMatch;
      end
    end else begin
      if (cfg_wr && cfg_paddr[2] == RegActivePatterns[2]) begin
        active_r <= cfg_pwdata[ActW-1:0];
      end
      if (out_v_r && out_tready && !out_load) out_v_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && in_mode == MODE_SYMBOL) begin
            if (count_r < CntW'(Lookahead)) count_r <= count_r + CntW'(1);
            eot_r   <= in_tlast;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          p_r <= PcntW'(1);
          win_r    <= '0;
          winval_r <= best_r[0];
          if (scan_r < count_r) begin
            state_r <= ST_SYM;
          end else if (count_r == '0) begin
            state_r <= ST_FINISH;
          end else if (eot_r) begin
            forced_r <= 1'b0;
            state_r  <= ST_DEC_CMP;
          end else if (count_r >= CntW'(Lookahead)) begin
            forced_r <= 1'b1;
            state_r  <= ST_DEC_CMP;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_SYM: begin
          p_r <= '0;
          if (scan_r == '0) begin
            dead_r  <= '0;
            state_r <= ST_START_RD;
          end else begin
            state_r <= ST_FEED_RD;
          end
        end
        ST_START_RD: begin
          if (p_r == n_act) begin
            p_r     <= '0;
            state_r <= ST_FEED_RD;
          end else begin
            state_r <= ST_START_WR;
          end
        end
        ST_START_WR: begin
          best_r[pi] <= acc_q ? PosEmptyMatch : PosNoMatch;
          pst_r[pi]  <= '0;
          p_r        <= p_r + PcntW'(1);
          state_r    <= ST_START_RD;
        end
        ST_FEED_RD: begin
          if (p_r == n_act) begin
            if (all_dead) begin
              p_r      <= PcntW'(1);
              win_r    <= '0;
              winval_r <= best_r[0];
              forced_r <= 1'b0;
              state_r  <= ST_DEC_CMP;
            end else begin
              p_r     <= '0;
              state_r <= ST_REC_RD;
            end
          end else if (dead_r[pi]) begin
            p_r <= p_r + PcntW'(1);
          end else begin
            state_r <= ST_FEED_WR;
          end
        end
        ST_FEED_WR: begin
          if (trans_q[4]) begin
            dead_r[pi] <= 1'b1;
          end else begin
            pst_r[pi] <= trans_q[StW-1:0];
          end
          p_r     <= p_r + PcntW'(1);
          state_r <= ST_FEED_RD;
        end
        ST_REC_RD: begin
          if (p_r == n_act) begin
            scan_r  <= scan_r + CntW'(1);
            state_r <= ST_SCAN;
          end else if (dead_r[pi]) begin
            p_r <= p_r + PcntW'(1);
          end else begin
            state_r <= ST_REC_WR;
          end
        end
        ST_REC_WR: begin
          if (acc_q) best_r[pi] <= pos_t'(scan_r);
          p_r     <= p_r + PcntW'(1);
          state_r <= ST_REC_RD;
        end
        ST_DEC_CMP: begin
          if (p_r == n_act) begin
            state_r <= ST_DEC_EMIT;
          end else begin
            if (best_r[pi] > winval_r) begin
              win_r    <= pi;
              winval_r <= best_r[pi];
            end
            p_r <= p_r + PcntW'(1);
          end
        end
        ST_DEC_EMIT: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_v_r    <= 1'b1;
              out_r      <= pend_r;
              out_last_r <= 1'b0;
            end
            pend_v_r <= 1'b1;
            pend_r   <= dec_res;
            head_r   <= head_r + dec_cons[BufAw-1:0];
            count_r  <= count_r - CntW'(dec_cons);
            scan_r   <= '0;
            state_r  <= ST_SCAN;
          end
        end
        ST_FINISH: begin
          if (!pend_v_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_v_r    <= 1'b1;
            out_r      <= pend_r;
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_r.token_id, out_r.consumed_length, out_r.token_length};
  assign out_tuser  = out_r.overflow;
  assign out_tlast  = out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegActivePatterns[2]) ?
                      {(CfgDw-ActW)'(0), active_r} : '0;

endmodule : multi_dfa_longest_match_lexer_unit
`default_nettype wire

### bench/mdlex_checker.sv
`timescale 1ns / 100ps
// Checker for the multi-DFA lexer: watches the channels, predicts tokens and compares them.
module mdlex_checker
  import mdlex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          errors,
  output int          pending,
  output int          tokens_seen
);

  typedef struct {
    logic [6:0] tlen;
    logic [6:0] cons;
    logic [2:0] id;
    logic       ovf;
    logic       last;
  } token_t;

  token_t      expected_tokens[$];
  logic [4:0]  trans[NumPatterns][NumStates][2];
  logic        acc[NumPatterns][NumStates];
  logic [3:0]  dfa_state[NumPatterns];
  int          best_pos[NumPatterns];
  logic        sym_buf[Lookahead];
  int          buf_cnt;
  int          scan;
  logic [3:0]  dead;
  logic [2:0]  active_reg;

  function automatic int num_active();
    if (active_reg < 1) return 1;
    if (active_reg > NumPatterns) return NumPatterns;
    return active_reg;
  endfunction

  function automatic bit all_dead();
    for (int p = 0; p < num_active(); p++) if (!dead[p]) return 0;
    return 1;
  endfunction

  task automatic emit_token(bit forced);
    int win;
    int b;
    int cons;
    int tlen;
    int id;
    token_t t;
    win = 0;
    for (int p = 1; p < num_active(); p++) if (best_pos[p] > best_pos[win]) win = p;
    b = best_pos[win];
    if (b < 0) begin
      cons = (scan != 0) ? scan : 1;
      tlen = (b == -2) ? cons : 0;
      id = 0;
    end else begin
      cons = b + 1;
      tlen = cons;
      id = win + 1;
    end
    if (cons > buf_cnt) cons = buf_cnt;
    t.tlen = tlen[6:0];
    t.cons = cons[6:0];
    t.id = id[2:0];
    t.ovf = forced;
    t.last = 0;
    expected_tokens.insert(expected_tokens.size(), t);
    for (int i = 0; i < Lookahead; i++) if (i + cons < Lookahead) sym_buf[i] = sym_buf[i + cons];
    buf_cnt -= cons;
    scan = 0;
  endtask

  task automatic lex_symbol(logic sym, logic eot);
    int n0;
    bit decided;
    logic [4:0] e;
    n0 = expected_tokens.size();
    if (buf_cnt < Lookahead) begin
      sym_buf[buf_cnt] = sym;
      buf_cnt++;
    end
    forever begin
      decided = 0;
      while (scan < buf_cnt) begin
        if (scan == 0) begin
          dead = '0;
          for (int p = 0; p < num_active(); p++) begin
            dfa_state[p] = '0;
            best_pos[p] = acc[p][0] ? -1 : -2;
          end
        end
        for (int p = 0; p < num_active(); p++) begin
          if (!dead[p]) begin
            e = trans[p][dfa_state[p]][sym_buf[scan]];
            if (e[4]) dead[p] = 1;
            else dfa_state[p] = e[3:0];
          end
        end
        if (all_dead()) begin
          emit_token(0);
          decided = 1;
          break;
        end
        for (int p = 0; p < num_active(); p++)
          if (!dead[p] && acc[p][dfa_state[p]]) best_pos[p] = scan;
        scan++;
      end
      if (decided) continue;
      if (buf_cnt == 0) break;
      if (eot) begin
        emit_token(0);
        continue;
      end
      if (buf_cnt >= Lookahead) begin
        emit_token(1);
        continue;
      end
      break;
    end
    if (expected_tokens.size() > n0) expected_tokens[$].last = 1;
  endtask

  always @(posedge clk) begin
    token_t t;
    logic [6:0] a_tlen;
    logic [6:0] a_cons;
    logic [2:0] a_id;
    if (!rst_n) begin
      expected_tokens.delete();
      buf_cnt = 0;
      scan = 0;
      dead = '0;
      active_reg = ActiveReset;
      errors <= 0;
      tokens_seen <= 0;
      for (int p = 0; p < NumPatterns; p++) begin
        dfa_state[p] = '0;
        best_pos[p] = -2;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == RegActivePatterns)
        active_reg = cfg_pwdata[2:0];
      if (in_tvalid && in_tready) begin
        case (mode_t'(in_tuser))
          MODE_LOAD_TRANS: trans[in_tdata[1:0]][in_tdata[5:2]][in_tdata[6]] = in_tdata[11:7];
          MODE_LOAD_ACCEPT: acc[in_tdata[1:0]][in_tdata[5:2]] = in_tdata[12];
          MODE_SYMBOL: lex_symbol(in_tdata[6], in_tlast);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        a_tlen = out_tdata[6:0];
        a_cons = out_tdata[13:7];
        a_id = out_tdata[16:14];
        tokens_seen <= tokens_seen + 1;
        if (expected_tokens.size() == 0) begin
          $display("%0t: token with none expected: len %0d cons %0d id %0d", $time,
                   a_tlen, a_cons, a_id);
          errors <= errors + 1;
        end else begin
          t = expected_tokens.pop_front();
          if (t.tlen !== a_tlen || t.cons !== a_cons || t.id !== a_id ||
              t.ovf !== out_tuser || t.last !== out_tlast || out_tdata[23:17] !== '0) begin
            $display("%0t: mismatch exp len %0d cons %0d id %0d ovf %0d last %0d", $time,
                     t.tlen, t.cons, t.id, t.ovf, t.last);
            $display("%0t:          act len %0d cons %0d id %0d ovf %0d last %0d pad %0h",
                     $time, a_tlen, a_cons, a_id, out_tuser, out_tlast, out_tdata[23:17]);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_tokens.size();
  end

endmodule

### bench/multi_dfa_longest_match_lexer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the multi-DFA lexer: stimulus, idling, watchdog and verdict.
module multi_dfa_longest_match_lexer_unit_tb;
  import mdlex_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = MODE_NONE;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors;
  int pending;
  int tokens_seen;
  int cycles = 0;
  int symbols_sent = 0;
  int loads_sent = 0;
  bit quiet = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  multi_dfa_longest_match_lexer_unit DUT (.*);

  mdlex_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send(mode_t m, logic [1:0] pat, logic [3:0] st, logic sym,
                      logic [3:0] ns, logic nd, logic accv, logic eot);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tuser <= m;
    in_tdata <= {3'b000, accv, nd, ns, sym, st, pat};
    in_tlast <= eot;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    if (m == MODE_SYMBOL) symbols_sent++;
    else loads_sent++;
  endtask

  task automatic send_symbol(logic sym, logic eot);
    send(MODE_SYMBOL, 2'($urandom), 4'($urandom), sym, 4'($urandom), 1'($urandom),
         1'($urandom), eot);
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    do @(posedge clk); while (pending != 0 || !in_tready);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_active(logic [2:0] v);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= RegActivePatterns;
    cfg_pwdata <= {29'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // looping: every DFA stays alive and never accepts, so the buffer fills
  task automatic load_transition(int p, int s, int c, bit looping);
    logic [3:0] ns;
    logic nd;
    ns = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    nd = looping ? 1'b0 : ($urandom_range(0, 3) == 0);
    if (looping) ns = 4'($urandom);
    send(MODE_LOAD_TRANS, p[1:0], s[3:0], c[0], ns, nd, 1'($urandom), 1'($urandom));
  endtask

  task automatic load_accept(int p, int s, bit looping);
    logic a;
    a = looping ? 1'b0 : ((s == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 2) == 0));
    send(MODE_LOAD_ACCEPT, p[1:0], s[3:0], 1'($urandom), 4'($urandom), 1'($urandom), a,
         1'($urandom));
  endtask

  task automatic load_tables(bit looping);
    for (int p = 0; p < NumPatterns; p++)
      for (int s = 0; s < NumStates; s++) begin
        load_transition(p, s, 0, looping);
        load_transition(p, s, 1, looping);
        load_accept(p, s, looping);
      end
  endtask

  initial begin
    int len;
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    quiet = 1;
    load_tables(0);
    quiet = 0;

    // directed: unused mode, single symbols, empty and accepting start states
    send(MODE_NONE, 2'd3, 4'd15, 1'b1, 4'd15, 1'b1, 1'b1, 1'b1);
    send_symbol(0, 1);
    send_symbol(1, 1);
    send(MODE_LOAD_ACCEPT, 2'd0, 4'd0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0);
    send(MODE_LOAD_TRANS, 2'd0, 4'd0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_symbol(i[0], i == 5);
    send(MODE_LOAD_TRANS, 2'd3, 4'd0, 1'b0, 4'd15, 1'b0, 1'b0, 1'b0);
    send(MODE_LOAD_TRANS, 2'd3, 4'd15, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) send_symbol(i < 4, i == 7);
    wait_idle();

    phase = 0;
    while (symbols_sent < 260) begin
      write_active((phase == 0) ? 3'd1 : (phase == 1) ? 3'd4 : (phase == 2) ? 3'd0 :
                   (phase == 3) ? 3'd7 : 3'($urandom_range(1, 4)));
      quiet = ($urandom_range(0, 4) == 0);
      if (phase == 4) begin
        load_tables(1);
        for (int i = 0; i < 70; i++) send_symbol(1'($urandom), i == 69);
        wait_idle();
        load_tables(0);
      end else begin
        if (phase % 3 == 2) load_tables(0);
        for (int w = 0; w < 4; w++) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
              load_transition($urandom_range(0, 3), $urandom_range(0, 15),
                              $urandom_range(0, 1), 0);
            if ($urandom_range(0, 20) == 0)
              send(MODE_NONE, 2'($urandom), 4'($urandom), 1'($urandom), 4'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
            send_symbol(1'($urandom), (i == len - 1) && ($urandom_range(0, 5) != 0));
          end
        end
        send_symbol(1'($urandom), 1);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    $display("Sent %0d text symbols and %0d table or unused items over %0d phases;",
             symbols_sent, loads_sent, phase);
    $display("checked %0d tokens, including forced and unmatched decisions.", tokens_seen);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mdlex_pkg.sv
hw/rtl/multi_dfa_longest_match_lexer_unit.sv
bench/mdlex_checker.sv
bench/multi_dfa_longest_match_lexer_unit_tb.sv
